@@ hdl/sliding_window_image_filter_assert.svh @@
// Assertion macros for the sliding window image filter.
// Needs a clock named clk and a synchronous active-low reset named rst_n in scope.
`ifndef SLIDING_WINDOW_IMAGE_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_IMAGE_FILTER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SWIF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence on the next clock.
`define SWIF_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ hdl/swif_pkg.sv @@
// Package for the sliding window image filter: widths, codes and shared types.
// Has no dependencies; every module of the filter imports it.
`timescale 1ns / 1ps

package swif_pkg;

  localparam int SWIF_MAX_WIDTH  = 1024;
  localparam int SWIF_MAX_HEIGHT = 1024;
  localparam int SWIF_MAX_FILTER = 5;

  localparam int PIX_W      = 16;
  localparam int PROD_W     = 32;
  localparam int SUM_W      = 36;
  localparam int POS_W      = 10;
  localparam int CIDX_W     = 5;
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_K_W    = 3;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FILTER_SIZE  = 2'd2
  } cfg_reg_t;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic en;
    logic shift;
  } swif_cell_ctl_t;

endpackage

@@ hdl/swif_line_mem.sv @@
// Line store: one word per image column holding that column's most recent rows.
// Write-first on a same-address read and write; depends on swif_pkg.
`timescale 1ns / 1ps

module swif_line_mem import swif_pkg::*; #(
  parameter int DEPTH = SWIF_MAX_WIDTH,
  parameter int AW    = $clog2(SWIF_MAX_WIDTH),
  parameter int DW    = SWIF_MAX_FILTER * PIX_W
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/swif_cell.sv @@
// One window column cell: holds a column of pixels, passes it to its neighbor,
// and forms the registered products and column sum. Depends on swif_pkg.
`timescale 1ns / 1ps

module swif_cell import swif_pkg::*; #(
  parameter int ROWS = SWIF_MAX_FILTER
) (
  input  logic                             clk,
  input  swif_cell_ctl_t                   ctl,
  input  logic [ROWS-1:0][PIX_W-1:0]       col_in,
  input  logic [ROWS-1:0][PIX_W-1:0]       coef,
  output logic [ROWS-1:0][PIX_W-1:0]       col_out,
  output logic signed [SUM_W-1:0]          col_sum
);

  logic [ROWS-1:0][PIX_W-1:0] pix_r;
  logic signed [PROD_W-1:0]   prod_r [ROWS];
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SUM_W-1:0]    sum_r;

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.shift) begin
      pix_r <= col_in;
    end
  end

  // A tap outside the filter in use has a zero coefficient, and its pixel may never
  // have been written, so its product is forced to zero.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int i = 0; i < ROWS; i++) begin
        if (coef[i] == '0) begin
          prod_r[i] <= '0;
        end else begin
          prod_r[i] <= $signed(pix_r[i]) * $signed(coef[i]);
        end
      end
      sum_r <= sum_nxt;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < ROWS; i++) begin
      sum_nxt = sum_nxt + SUM_W'(prod_r[i]);
    end
  end

  assign col_out = pix_r;
  assign col_sum = sum_r;

endmodule

@@ hdl/sliding_window_image_filter.sv @@
// Channel | Direction | Contents
// in      | input     | op, coef_index, coef_value, pixel (valid/ready)
// out     | output    | out_row, out_col, out_value (valid/ready)
// cfg     | input     | cfg_index, cfg_data (valid/ready, always ready)
// One item is accepted per clock while the output is not stalled.
// A result passes the line store read and input registers, the cell pixel, product, column sum and total registers.
// Reset is synchronous; it restores the configuration registers and clears valid flags, coefficients and counters.
// A stalled output holds the whole pipeline and drops in_ready.
// Top level of the sliding window image filter; uses swif_pkg, swif_line_mem, swif_cell.
`timescale 1ns / 1ps
`include "sliding_window_image_filter_assert.svh"

module sliding_window_image_filter import swif_pkg::*; #(
  parameter int MAX_WIDTH  = SWIF_MAX_WIDTH,
  parameter int MAX_HEIGHT = SWIF_MAX_HEIGHT,
  parameter int MAX_FILTER = SWIF_MAX_FILTER
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [CIDX_W-1:0]       in_coef_index,
  input  logic signed [PIX_W-1:0] in_coef_value,
  input  logic signed [PIX_W-1:0] in_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic signed [SUM_W-1:0] out_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DIM_W-1:0]    cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CDW  = CW + 1;
  localparam int RDW  = RW + 1;
  localparam int WXW  = (CDW > CFG_DIM_W) ? CDW : CFG_DIM_W;
  localparam int HXW  = (RDW > CFG_DIM_W) ? RDW : CFG_DIM_W;
  localparam int KW   = $clog2(MAX_FILTER + 1);
  localparam int TAPS = MAX_FILTER * MAX_FILTER;
  localparam int TAPW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int LW   = MAX_FILTER * PIX_W;

  logic [CFG_DIM_W-1:0] width_r, height_r;
  logic [CFG_K_W-1:0]   fsize_r;
  logic [WXW-1:0]       w_x;
  logic [HXW-1:0]       h_x;
  logic [CFG_K_W-1:0]   k_x;
  logic [CDW-1:0]       w_eff;
  logic [RDW-1:0]       h_eff;
  logic [KW-1:0]        k_eff;

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CDW-1:0] col_inc;
  logic [RDW-1:0] row_inc;
  logic           emit0;
  logic           adv, acc, cfg_wr;

  logic                    s1_v_r;
  logic                    s1_op_r;
  logic [PIX_W-1:0]        s1_pix_r;
  logic [CW-1:0]           s1_col_r;
  logic                    s1_emit_r;
  logic [RW-1:0]           s1_orow_r;
  logic [CW-1:0]           s1_ocol_r;
  logic [CIDX_W-1:0]       s1_cidx_r;
  logic [PIX_W-1:0]        s1_cval_r;
  logic                    s1_pixel;

  logic                    m2_v_r, m3_v_r, m4_v_r, out_valid_r;
  logic [RW-1:0]           m2_row_r, m3_row_r, m4_row_r;
  logic [CW-1:0]           m2_col_r, m3_col_r, m4_col_r;
  logic [POS_W-1:0]        out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_value_r, total_nxt;

  logic [PIX_W-1:0]        coef_r [TAPS];
  logic [MAX_FILTER-1:0][PIX_W-1:0] coef_sel [MAX_FILTER];
  logic [MAX_FILTER-1:0][PIX_W-1:0] col_vec;
  logic [MAX_FILTER-1:0][PIX_W-1:0] rd_col;
  logic [MAX_FILTER-1:0][PIX_W-1:0] chain [MAX_FILTER+1];
  logic signed [SUM_W-1:0]          col_sum [MAX_FILTER];
  logic [LW-1:0]                    rd_data;
  swif_cell_ctl_t                   cell_ctl;

  assign w_x   = WXW'(width_r);
  assign h_x   = HXW'(height_r);
  assign w_eff = CDW'((w_x == '0) ? WXW'(1) : ((w_x > WXW'(MAX_WIDTH)) ? WXW'(MAX_WIDTH) : w_x));
  assign h_eff = RDW'((h_x == '0) ? HXW'(1)
                                  : ((h_x > HXW'(MAX_HEIGHT)) ? HXW'(MAX_HEIGHT) : h_x));
  assign k_x   = (fsize_r == '0) ? CFG_K_W'(1)
               : ((fsize_r > CFG_K_W'(MAX_FILTER)) ? CFG_K_W'(MAX_FILTER) : fsize_r);
  assign k_eff = KW'(k_x);

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign acc       = in_valid && adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign col_inc = {1'b0, col_r} + CDW'(1);
  assign row_inc = {1'b0, row_r} + RDW'(1);
  assign emit0   = (row_inc >= RDW'(k_eff)) && (col_inc >= CDW'(k_eff));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc && (in_op == OP_PIXEL)) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : RW'(row_inc);
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_DIM_W'(1024);
      height_r <= CFG_DIM_W'(1024);
      fsize_r  <= CFG_K_W'(3);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        CFG_FILTER_SIZE:  fsize_r  <= cfg_data[CFG_K_W-1:0];
        default:          ;
      endcase
      if ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT) ||
          (cfg_index == CFG_FILTER_SIZE)) begin
        col_r <= '0;
        row_r <= '0;
      end
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      m3_v_r      <= 1'b0;
      m4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= acc;
      m2_v_r      <= s1_pixel && s1_emit_r;
      m3_v_r      <= m2_v_r;
      m4_v_r      <= m3_v_r;
      out_valid_r <= m4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= in_op;
      s1_pix_r  <= in_pixel;
      s1_col_r  <= col_r;
      s1_emit_r <= emit0;
      s1_orow_r <= row_r - RW'(k_eff >> 1);
      s1_ocol_r <= col_r - CW'(k_eff >> 1);
      s1_cidx_r <= in_coef_index;
      s1_cval_r <= in_coef_value;
      m2_row_r  <= s1_orow_r;
      m2_col_r  <= s1_ocol_r;
      m3_row_r  <= m2_row_r;
      m3_col_r  <= m2_col_r;
      m4_row_r  <= m3_row_r;
      m4_col_r  <= m3_col_r;
      out_row_r <= POS_W'(m4_row_r);
      out_col_r <= POS_W'(m4_col_r);
      out_value_r <= total_nxt;
    end
  end

  assign s1_pixel = s1_v_r && (s1_op_r == OP_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TAPS; t++) begin
        coef_r[t] <= '0;
      end
    end else if (adv && s1_v_r && (s1_op_r == OP_COEF) &&
                 ({1'b0, s1_cidx_r} < (CIDX_W + 1)'(TAPS))) begin
      coef_r[TAPW'(s1_cidx_r)] <= s1_cval_r;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_FILTER; j++) begin
      coef_sel[j] = '0;
    end
    for (int kk = 1; kk <= MAX_FILTER; kk++) begin
      if (k_eff == KW'(kk)) begin
        for (int j = 0; j < kk; j++) begin
          for (int i = 0; i < kk; i++) begin
            coef_sel[j][i] = coef_r[TAPW'((kk - 1 - i) * kk + (kk - 1 - j))];
          end
        end
      end
    end
  end

  assign rd_col = rd_data;

  always_comb begin
    col_vec[0] = s1_pix_r;
    for (int i = 1; i < MAX_FILTER; i++) begin
      col_vec[i] = rd_col[i-1];
    end
  end

  swif_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (LW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (adv && s1_pixel),
    .wr_addr (s1_col_r),
    .wr_data (col_vec)
  );

  assign cell_ctl.en    = adv;
  assign cell_ctl.shift = s1_pixel;
  assign chain[0]       = col_vec;

  for (genvar j = 0; j < MAX_FILTER; j++) begin : g_cell
    swif_cell #(
      .ROWS (MAX_FILTER)
    ) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .col_in  (chain[j]),
      .coef    (coef_sel[j]),
      .col_out (chain[j+1]),
      .col_sum (col_sum[j])
    );
  end

  always_comb begin
    total_nxt = '0;
    for (int j = 0; j < MAX_FILTER; j++) begin
      total_nxt = total_nxt + col_sum[j];
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;

  `SWIF_ASSERT_ALWAYS(a_col_in_range, {1'b0, col_r} < w_eff, "column counter beyond width")
  `SWIF_ASSERT_ALWAYS(a_row_in_range, {1'b0, row_r} < h_eff, "row counter beyond height")
  `SWIF_ASSERT_NEXT(a_result_reaches_out, m4_v_r && adv, out_valid, "result lost before output")

endmodule

@@ tb/sliding_window_image_filter_test.sv @@
// Self-checking testbench for the sliding window image filter: streams coefficients and pixels,
// predicts every filtered result and checks each one field by field. Depends on swif_pkg.
`timescale 1ns / 1ps

module sliding_window_image_filter_test;
  import swif_pkg::*;

  typedef struct {
    logic                    op;
    logic [CIDX_W-1:0]       idx;
    logic signed [PIX_W-1:0] cval;
    logic signed [PIX_W-1:0] pix;
  } filt_item_t;

  typedef struct {
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_PIXEL;
  logic [CIDX_W-1:0] in_coef_index = '0;
  logic signed [PIX_W-1:0] in_coef_value = '0;
  logic signed [PIX_W-1:0] in_pixel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic signed [SUM_W-1:0] out_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DIM_W-1:0] cfg_data = '0;

  filt_item_t   feed_q[$];
  filt_result_t window_sum_q[$];
  filt_item_t   cur_item;
  int  err_count = 0;
  int  idle_pct = 17;
  int  out_hold = 0;
  bit  feed_pause = 1'b0;

  logic signed [PIX_W-1:0] row_mem[SWIF_MAX_FILTER][SWIF_MAX_WIDTH];
  logic signed [PIX_W-1:0] taps[SWIF_MAX_FILTER*SWIF_MAX_FILTER];
  int unsigned row_pos, col_pos, reg_w, reg_h, reg_k;

  sliding_window_image_filter u_top (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("sliding_window_image_filter_test: errors");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic predict_window(filt_item_t it);
    int unsigned w, h, k, top, left;
    longint acc;
    filt_result_t res;
    w = clamp_dim(reg_w, SWIF_MAX_WIDTH);
    h = clamp_dim(reg_h, SWIF_MAX_HEIGHT);
    k = clamp_dim(reg_k, SWIF_MAX_FILTER);
    if (it.op == OP_COEF) begin
      if (it.idx < SWIF_MAX_FILTER*SWIF_MAX_FILTER) taps[it.idx] = it.cval;
      return;
    end
    if (col_pos >= w || row_pos >= h) begin
      row_pos = 0;
      col_pos = 0;
    end
    row_mem[row_pos % SWIF_MAX_FILTER][col_pos] = it.pix;
    if (row_pos + 1 >= k && col_pos + 1 >= k) begin
      acc = 0;
      top = row_pos + 1 - k;
      left = col_pos + 1 - k;
      for (int x = 0; x < k; x++)
        for (int y = 0; y < k; y++)
          acc += longint'(row_mem[(top + x) % SWIF_MAX_FILTER][left + y]) *
                 longint'(taps[x*k + y]);
      res.row = POS_W'(row_pos - k/2);
      res.col = POS_W'(col_pos - k/2);
      res.value = acc[SUM_W-1:0];
      window_sum_q.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_window(cur_item);
      if (!in_valid || in_ready) begin
        if (feed_q.size() > 0 && !feed_pause && $urandom_range(99) >= idle_pct) begin
          cur_item = feed_q.pop_front();
          in_valid <= 1'b1;
          in_op <= cur_item.op;
          in_coef_index <= cur_item.idx;
          in_coef_value <= cur_item.cval;
          in_pixel <= cur_item.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    filt_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (window_sum_q.size() == 0) begin
          report($sformatf("unexpected result row %0d col %0d", out_row, out_col));
        end else begin
          e = window_sum_q.pop_front();
          if (out_row !== e.row)
            report($sformatf("out_row %0d, want %0d", out_row, e.row));
          if (out_col !== e.col)
            report($sformatf("out_col %0d, want %0d", out_col, e.col));
          if (out_value !== e.value)
            report($sformatf("out_value %0d, want %0d at (%0d,%0d)",
                             out_value, e.value, e.row, e.col));
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic push_coef(int idx, logic signed [PIX_W-1:0] v);
    filt_item_t it;
    it.op = OP_COEF;
    it.idx = CIDX_W'(idx);
    it.cval = v;
    it.pix = PIX_W'($urandom);
    feed_q.push_back(it);
  endtask

  task automatic push_pixel(logic signed [PIX_W-1:0] p);
    filt_item_t it;
    it.op = OP_PIXEL;
    it.idx = CIDX_W'($urandom);
    it.cval = PIX_W'($urandom);
    it.pix = p;
    feed_q.push_back(it);
  endtask

  // Waits until every item is sent and every result checked, then lets the pipeline drain.
  task automatic wait_drained();
    bit busy;
    busy = 1'b1;
    while (busy) begin
      @(negedge clk);
      busy = (feed_q.size() > 0) || in_valid || (window_sum_q.size() > 0);
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, int unsigned data);
    bit ok;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DIM_W'(data);
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  reg_w = data & 11'h7FF;
      CFG_IMAGE_HEIGHT: reg_h = data & 11'h7FF;
      CFG_FILTER_SIZE:  reg_k = data & 3'h7;
      default:          return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned k);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
    cfg_write(CFG_FILTER_SIZE, k);
  endtask

  task automatic random_phase(int unsigned w, int unsigned h, int unsigned k, int n);
    setup(w, h, k);
    for (int i = 0; i < 25; i++) push_coef(i, PIX_W'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 6) push_coef($urandom_range(0, 31), PIX_W'($urandom));
      else push_pixel(PIX_W'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 25; i++) taps[i] = '0;
    for (int i = 0; i < SWIF_MAX_FILTER; i++)
      for (int j = 0; j < SWIF_MAX_WIDTH; j++) row_mem[i][j] = '0;
    row_pos = 0;
    col_pos = 0;
    reg_w = 1024;
    reg_h = 1024;
    reg_k = 3;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme coefficients and pixels, ignored tap indexes and config index, small image.
    cfg_write(CFG_IMAGE_WIDTH, 4);
    cfg_write(CFG_IMAGE_HEIGHT, 4);
    for (int i = 0; i < 9; i++) push_coef(i, (i % 2) ? 16'sh8000 : 16'sh7FFF);
    push_coef(25, 16'sh1234);
    push_coef(31, 16'sh8000);
    for (int i = 0; i < 12; i++) push_pixel((i % 3 == 0) ? 16'sh8000 : 16'sh7FFF);
    wait_drained();
    cfg_write(cfg_reg_t'(2'd3), 5);
    push_pixel(16'sh0001);
    push_pixel(16'shFFFF);
    push_pixel(16'sh0000);
    push_pixel(16'sh8000);
    wait_drained();

    // Filter larger than the image, and degenerate sizes.
    random_phase(3, 3, 5, 20);
    random_phase(0, 0, 0, 10);
    random_phase(5, 4, 6, 40);
    random_phase(7, 6, 7, 40);

    // Long output stall with no input gaps so the block backs up.
    idle_pct = 0;
    out_hold = 300;
    random_phase(6, 6, 3, 100);

    idle_pct = 17;
    for (int p = 0; p < 2; p++)
      random_phase($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(1, 5), 50);

    // Extremes of the dimensions, kept short in the other direction.
    random_phase(2047, 2, 1, 1028);
    random_phase(1, 2047, 0, 20);

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("sliding_window_image_filter_test: clean");
    end else begin
      $display("sliding_window_image_filter_test: errors");
    end
    $finish;
  end

endmodule
